@@ hw/rtl/rsa_modular_exponentiation_defines.svh @@
// Assertion macros for the checker file of the exponentiation block.
// Needs nothing else; include by bare file name.
`ifndef RSA_MODULAR_EXPONENTIATION_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rme: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rme: next-cycle check failed");

`endif

@@ hw/rtl/rme_pkg.sv @@
// Package for the modular exponentiation block: defaults, register indexes,
// opcodes and the sequencer state type. No dependencies.
package rme_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int CFG_IDX_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd2;

    // opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQR,
        S_MUL,
        S_WAIT
    } t_state;

endpackage

@@ hw/rtl/rme_in_if.sv @@
// Input channel of the exponentiation block: valid/ready plus opcode and value.
// Depends on rme_pkg for the default width.
interface rme_in_if #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [WORD_BITS-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ hw/rtl/rme_out_if.sv @@
// Output channel of the exponentiation block: valid/ready plus result.
// Depends on rme_pkg for the default width.
interface rme_out_if #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

@@ hw/rtl/rsa_modular_exponentiation.sv @@
// Top level: bit-serial square-and-multiply modular exponentiation.
// Depends on rme_pkg, rme_in_if and rme_out_if.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+----------------------------------
//  i_in     | in  | valid/ready         | opcode (1b), value (WORD_BITS)
//  o_out    | out | valid/ready         | result (WORD_BITS)
//  i_cfg_*  | in  | write enable only   | idx (2b), data (WORD_BITS)
//
// The shared bit-serial modular product unit consumes one multiplier bit per cycle
// for the reduce, square and multiply steps; a zero exponent skips them all.
// One item at a time; the output register lets a new item start while the
// previous result still waits. Reset (synchronous, active low) clears control
// state and loads the register reset values; no clearing pass is needed.
module rsa_modular_exponentiation #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rme_in_if.sink                         i_in,
    rme_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WORD_BITS-1:0]           i_cfg_data
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(WORD_BITS);
    localparam int XW = WORD_BITS + 3;   // room for 2*acc + b - 2*M, signed

    // configuration
    logic [W-1:0] r_pub_exp;
    logic [W-1:0] r_priv_exp;
    logic [W-1:0] r_modulus;

    // sequencer and datapath registers
    rme_pkg::t_state r_state, n_state;
    logic [W-1:0]  r_acc,  n_acc;    // partial product, always < M
    logic [W-1:0]  r_a,    n_a;      // multiplier, shifts out MSB first
    logic [W-1:0]  r_b,    n_b;      // multiplicand, <= M
    logic [W-1:0]  r_base, n_base;   // value mod M
    logic [W-1:0]  r_exp,  n_exp;    // exponent, shifts out MSB first
    logic [W-1:0]  r_pow,  n_pow;    // running power / finished result
    logic [CW-1:0] r_bcnt, n_bcnt;   // multiplier bits left after this one
    logic [CW-1:0] r_ecnt, n_ecnt;   // exponent bits left after this one

    // output register
    logic          r_ovalid;
    logic [W-1:0]  r_result;

    logic          w_in_acc;
    logic          w_out_free;
    logic [W-1:0]  w_exp_sel;
    logic          w_last;
    logic [W:0]    w_modx;
    logic [W-1:0]  w_badd;
    logic [XW-1:0] w_t;
    logic [XW-1:0] w_d1;
    logic [XW-1:0] w_d2;
    logic [W-1:0]  w_step;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_exp_sel  = (i_in.opcode == rme_pkg::OP_DECRYPT) ? r_priv_exp : r_pub_exp;
    assign w_last     = (r_bcnt == '0);

    // A zero modulus register stands for 2^W: one extra top bit keeps the
    // arithmetic uniform and makes every step wrap naturally.
    assign w_modx = {(r_modulus == '0), r_modulus};

    // One interleaved step: acc = (2*acc + bit*b) mod M. With acc < M and
    // b <= M the sum is below 3M, so at most two subtractions of M.
    assign w_badd = r_a[W-1] ? r_b : '0;
    assign w_t    = XW'({r_acc, 1'b0}) + XW'(w_badd);
    assign w_d1   = w_t - XW'(w_modx);
    assign w_d2   = w_t - XW'({w_modx, 1'b0});

    always_comb begin
        if (!w_d2[XW-1]) begin
            w_step = w_d2[W-1:0];
        end else if (!w_d1[XW-1]) begin
            w_step = w_d1[W-1:0];
        end else begin
            w_step = w_t[W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rme_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (w_exp_sel == '0) ? rme_pkg::S_WAIT : rme_pkg::S_REDUCE;
                end
            end
            rme_pkg::S_REDUCE: begin
                if (w_last) begin
                    n_state = rme_pkg::S_SQR;
                end
            end
            rme_pkg::S_SQR: begin
                if (w_last) begin
                    if (r_exp[W-1]) begin
                        n_state = rme_pkg::S_MUL;
                    end else if (r_ecnt == '0) begin
                        n_state = rme_pkg::S_WAIT;
                    end else begin
                        n_state = rme_pkg::S_SQR;
                    end
                end
            end
            rme_pkg::S_MUL: begin
                if (w_last) begin
                    n_state = (r_ecnt == '0) ? rme_pkg::S_WAIT : rme_pkg::S_SQR;
                end
            end
            rme_pkg::S_WAIT: begin
                if (w_out_free) begin
                    n_state = rme_pkg::S_IDLE;
                end
            end
            default: n_state = rme_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_base = r_base;
        n_exp  = r_exp;
        n_pow  = r_pow;
        n_bcnt = r_bcnt;
        n_ecnt = r_ecnt;
        case (r_state)
            rme_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    // reduce value mod M first: shift value in against b = 1
                    n_acc  = '0;
                    n_a    = i_in.value;
                    n_b    = W'(1);
                    n_bcnt = CW'(W - 1);
                    n_exp  = w_exp_sel;
                    n_ecnt = CW'(W - 1);
                    n_pow  = W'(1);
                end
            end
            rme_pkg::S_REDUCE, rme_pkg::S_SQR, rme_pkg::S_MUL: begin
                n_acc  = w_step;
                n_a    = r_a << 1;
                n_bcnt = r_bcnt - 1'b1;
                if (w_last) begin
                    n_acc  = '0;
                    n_bcnt = CW'(W - 1);
                    if (r_state == rme_pkg::S_REDUCE) begin
                        // first square is 1*1
                        n_base = w_step;
                        n_a    = W'(1);
                        n_b    = W'(1);
                    end else if (r_state == rme_pkg::S_SQR && r_exp[W-1]) begin
                        n_a = w_step;
                        n_b = r_base;
                    end else begin
                        // exponent bit done
                        n_exp  = r_exp << 1;
                        n_ecnt = r_ecnt - 1'b1;
                        n_pow  = w_step;
                        n_a    = w_step;
                        n_b    = w_step;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
            r_modulus  <= W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rme_pkg::REG_PUB_EXP:  r_pub_exp  <= i_cfg_data;
                rme_pkg::REG_PRIV_EXP: r_priv_exp <= i_cfg_data;
                rme_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rme_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rme_pkg::S_WAIT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_b    <= n_b;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_pow  <= n_pow;
        r_bcnt <= n_bcnt;
        r_ecnt <= n_ecnt;
        if (r_state == rme_pkg::S_WAIT && w_out_free) begin
            r_result <= r_pow;
        end
    end

    assign i_in.ready   = (r_state == rme_pkg::S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.result = r_result;

endmodule

@@ hw/rtl/rme_checker.sv @@
// Port-level checker for the exponentiation block, bound to the top level.
// Depends on rme_pkg and rsa_modular_exponentiation_defines.svh.
`include "rsa_modular_exponentiation_defines.svh"

module rme_checker #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [WORD_BITS-1:0]          i_out_result,
    input logic                          i_cfg_we,
    input logic [rme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [WORD_BITS-1:0]          i_cfg_data
);

    logic [1:0]           r_cnt, n_cnt;   // items in flight
    logic [WORD_BITS-1:0] r_mod;          // shadow of the modulus register
    logic                 w_in_acc;
    logic                 w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt + 2'(w_in_acc) - 2'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_mod <= WORD_BITS'(1);
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_we && i_cfg_idx == rme_pkg::REG_MODULUS) begin
                r_mod <= i_cfg_data;
            end
        end
    end

    // the block works on one item at a time
    `RME_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !i_in_ready)

    // never more than one item computing plus one result waiting
    `RME_ASSERT_NOW(a_inflight_bound, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)

    // no result without an item behind it
    `RME_ASSERT_NOW(a_no_spurious_result, i_clk, i_rst_n, i_out_valid, r_cnt != 2'd0)

    // results are reduced below a modulus above one
    `RME_ASSERT_NOW(a_result_reduced, i_clk, i_rst_n,
                    i_out_valid && r_mod > WORD_BITS'(1), i_out_result < r_mod)

    // a stalled result holds
    `RME_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_out_result))

endmodule

bind rsa_modular_exponentiation rme_checker #(.WORD_BITS(WORD_BITS)) u_rme_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_idx    (i_cfg_idx),
    .i_cfg_data   (i_cfg_data)
);
